// File: hw/rtl/hct_pkg.sv
// types, status codes and constants of the handshake connection table
`default_nettype none

package hct_pkg;

    // slot numbers travel at the width of the result field
    localparam int SLOT_W = 6;
    localparam int PEER_W = 48;

    // result status codes
    localparam logic [3:0] STS_SYNACK      = 4'd0;
    localparam logic [3:0] STS_DUP_PEND    = 4'd1;
    localparam logic [3:0] STS_PEND_FULL   = 4'd2;
    localparam logic [3:0] STS_ESTAB       = 4'd3;
    localparam logic [3:0] STS_DUP_ESTAB   = 4'd4;
    localparam logic [3:0] STS_ESTAB_FULL  = 4'd5;
    localparam logic [3:0] STS_NOT_PEND    = 4'd6;
    localparam logic [3:0] STS_POPPED      = 4'd7;
    localparam logic [3:0] STS_EMPTY       = 4'd8;
    localparam logic [3:0] STS_IGNORED     = 4'd9;

    // command codes
    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_ACCEPT  = 1'b1;

    typedef struct packed {
        logic        command;
        logic        syn_flag;
        logic        ack_flag;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
    } hct_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        reply_valid;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [5:0]  slot;
        logic [31:0] out_addr;
        logic [15:0] out_port;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
    } hct_out_t;

    // requests from the sequencer to one peer table
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [PEER_W-1:0] wr_peer;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_slot;
        logic [SLOT_W-1:0] rd_slot;
    } hct_tbl_ctrl_t;

    // occupancy summary of one peer table
    typedef struct packed {
        logic              has_free;
        logic [SLOT_W-1:0] free_slot;
        logic              has_used;
        logic [SLOT_W-1:0] used_slot;
    } hct_tbl_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/hct_table.sv
// one peer table: peer memory with registered read, valid bits, slot search
`default_nettype none

module hct_table #(
    parameter int DEPTH = 8
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  hct_pkg::hct_tbl_ctrl_t     ctrl,
    output hct_pkg::hct_tbl_stat_t     stat,
    output logic [hct_pkg::PEER_W-1:0] rd_data,
    output logic                       rd_valid
);
    import hct_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SLOT_W:0] DEPTH_V = (SLOT_W+1)'(DEPTH);

    logic [PEER_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [PEER_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] clr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_ok;
    logic             clr_ok;
    logic             rd_ok;

    assign wr_idx  = ctrl.wr_slot[IDX_W-1:0];
    assign clr_idx = ctrl.clr_slot[IDX_W-1:0];
    assign rd_idx  = ctrl.rd_slot[IDX_W-1:0];
    assign wr_ok   = ctrl.wr_en  && ({1'b0, ctrl.wr_slot}  < DEPTH_V);
    assign clr_ok  = ctrl.clr_en && ({1'b0, ctrl.clr_slot} < DEPTH_V);
    assign rd_ok   = {1'b0, ctrl.rd_slot} < DEPTH_V;

    // lowest free and lowest used slot
    always_comb begin
        stat = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                stat.has_free  = 1'b1;
                stat.free_slot = SLOT_W'(i);
            end else begin
                stat.has_used  = 1'b1;
                stat.used_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (clr_ok) begin
            valid_next[clr_idx] = 1'b0;
        end
        if (wr_ok) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_idx] <= ctrl.wr_peer;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_idx];
    end

    // valid flag travels with the read word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_ok && valid_reg[rd_idx];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

    a_wr_free: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ok |-> !valid_reg[wr_idx])
        else $error("write into an occupied slot");

    a_clr_used: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_ok |-> valid_reg[clr_idx])
        else $error("clear of an empty slot");

    a_wr_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ok |=> valid_reg[$past(wr_idx)])
        else $error("written slot not marked valid");

endmodule

`default_nettype wire

// File: hw/rtl/handshake_connection_table.sv
// top level of the listener-side handshake connection table
//
//  channel  | ports                      | word      | direction
//  ---------+----------------------------+-----------+----------
//  segment  | s_valid s_ready s_data     | hct_in_t  | in
//  result   | m_valid m_ready m_data     | hct_out_t | out
//  config   | cfg_we cfg_wdata           | 32 bits   | in
//
//  a segment word passes dispatch, a scan over max(PENDING_SLOTS, ESTABLISHED_SLOTS)
//  slots and fin before the next accept; the scan reads one slot per cycle from each
//  table memory port, both tables in parallel, with a registered read
//  a pop runs dispatch, pop, fin; an empty accept or odd flag pair runs dispatch, fin
//  one word is in flight at a time; s_ready is high only in the idle state
//  the result register lets a new word enter while m_valid waits on m_ready
//  reset clears the valid bits of both tables at once: no clearing pass
`default_nettype none

module handshake_connection_table #(
    parameter int PENDING_SLOTS     = 8,
    parameter int ESTABLISHED_SLOTS = 8
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire [31:0]        cfg_wdata,
    input  wire               s_valid,
    output logic              s_ready,
    input  hct_pkg::hct_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output hct_pkg::hct_out_t m_data
);
    import hct_pkg::*;

    // scan runs over the deeper of the two tables
    localparam int SCAN_SLOTS = (PENDING_SLOTS > ESTABLISHED_SLOTS) ?
                                PENDING_SLOTS : ESTABLISHED_SLOTS;
    localparam int CNT_W = $clog2(SCAN_SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SCAN_SLOTS);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_POP      = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0]        state_reg,     state_next;
    hct_in_t           item_reg,      item_next;
    logic [31:0]       init_seq_reg,  init_seq_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [SLOT_W-1:0] cmp_slot_reg,  cmp_slot_next;
    logic              p_match_reg,   p_match_next;
    logic [SLOT_W-1:0] p_slot_reg,    p_slot_next;
    logic              e_match_reg,   e_match_next;
    logic [SLOT_W-1:0] pop_slot_reg,  pop_slot_next;
    hct_out_t          res_reg,       res_next;
    logic              m_valid_reg,   m_valid_next;
    hct_out_t          m_data_reg,    m_data_next;

    hct_tbl_ctrl_t     pend_ctrl, est_ctrl;
    hct_tbl_stat_t     pend_stat, est_stat;
    logic [PEER_W-1:0] pend_rd_data, est_rd_data;
    logic              pend_rd_valid, est_rd_valid;
    logic [PEER_W-1:0] peer;

    assign peer = {item_reg.peer_addr, item_reg.peer_port};

    hct_table #(.DEPTH(PENDING_SLOTS)) u_pend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (pend_ctrl),
        .stat     (pend_stat),
        .rd_data  (pend_rd_data),
        .rd_valid (pend_rd_valid)
    );

    hct_table #(.DEPTH(ESTABLISHED_SLOTS)) u_est (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (est_ctrl),
        .stat     (est_stat),
        .rd_data  (est_rd_data),
        .rd_valid (est_rd_valid)
    );

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        init_seq_next = init_seq_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_slot_next = cmp_slot_reg;
        p_match_next  = p_match_reg;
        p_slot_next   = p_slot_reg;
        e_match_next  = e_match_reg;
        pop_slot_next = pop_slot_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        // both tables read the scan slot unless a pop overrides the established table's read
        pend_ctrl         = '0;
        est_ctrl          = '0;
        pend_ctrl.rd_slot = SLOT_W'(cnt_reg);
        est_ctrl.rd_slot  = SLOT_W'(cnt_reg);
        pend_ctrl.wr_peer = peer;
        est_ctrl.wr_peer  = peer;

        if (cfg_we) begin
            init_seq_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_next     = '0;
                cnt_next     = '0;
                cmp_vld_next = 1'b0;
                p_match_next = 1'b0;
                e_match_next = 1'b0;
                if (item_reg.command == CMD_ACCEPT) begin
                    if (est_stat.has_used) begin
                        est_ctrl.rd_slot = est_stat.used_slot;
                        pop_slot_next    = est_stat.used_slot;
                        state_next       = S_POP;
                    end else begin
                        res_next.status = STS_EMPTY;
                        state_next      = S_FIN;
                    end
                end else if (item_reg.syn_flag != item_reg.ack_flag) begin
                    state_next = S_SCAN;
                end else begin
                    res_next.status = STS_IGNORED;
                    state_next      = S_FIN;
                end
            end
            S_SCAN: begin
                // compare stage: word read in the previous cycle
                if (cmp_vld_reg) begin
                    if (pend_rd_valid && pend_rd_data == peer) begin
                        p_match_next = 1'b1;
                        p_slot_next  = cmp_slot_reg;
                    end
                    if (est_rd_valid && est_rd_data == peer) begin
                        e_match_next = 1'b1;
                    end
                end
                if (cnt_reg != SCAN_END) begin
                    cmp_vld_next  = 1'b1;
                    cmp_slot_next = SLOT_W'(cnt_reg);
                    cnt_next      = cnt_reg + CNT_W'(1);
                end else begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg) begin
                        state_next = S_FIN;
                        if (item_reg.syn_flag) begin
                            // syn: new peer into the pending table
                            if (p_match_reg) begin
                                res_next.status = STS_DUP_PEND;
                            end else if (!pend_stat.has_free) begin
                                res_next.status = STS_PEND_FULL;
                            end else begin
                                pend_ctrl.wr_en      = 1'b1;
                                pend_ctrl.wr_slot    = pend_stat.free_slot;
                                res_next.status      = STS_SYNACK;
                                res_next.reply_valid = 1'b1;
                                res_next.reply_seq   = init_seq_reg;
                                res_next.reply_ack   = item_reg.seq_num + 32'd1;
                                res_next.slot        = pend_stat.free_slot;
                            end
                        end else begin
                            // ack: pending peer moves to the established table
                            if (e_match_reg) begin
                                res_next.status = STS_DUP_ESTAB;
                            end else if (!est_stat.has_free) begin
                                res_next.status = STS_ESTAB_FULL;
                            end else if (!p_match_reg) begin
                                res_next.status = STS_NOT_PEND;
                            end else begin
                                pend_ctrl.clr_en   = 1'b1;
                                pend_ctrl.clr_slot = p_slot_reg;
                                est_ctrl.wr_en     = 1'b1;
                                est_ctrl.wr_slot   = est_stat.free_slot;
                                res_next.status    = STS_ESTAB;
                                res_next.slot      = est_stat.free_slot;
                                res_next.out_seq   = item_reg.seq_num;
                                res_next.out_ack   = item_reg.ack_num;
                            end
                        end
                    end
                end
            end
            S_POP: begin
                est_ctrl.clr_en   = 1'b1;
                est_ctrl.clr_slot = pop_slot_reg;
                res_next.status   = STS_POPPED;
                res_next.slot     = pop_slot_reg;
                res_next.out_addr = est_rd_data[PEER_W-1:16];
                res_next.out_port = est_rd_data[15:0];
                state_next        = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            init_seq_reg <= '0;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            p_match_reg  <= 1'b0;
            e_match_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_seq_reg <= init_seq_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            p_match_reg  <= p_match_next;
            e_match_reg  <= e_match_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        cmp_slot_reg <= cmp_slot_next;
        p_slot_reg   <= p_slot_next;
        pop_slot_reg <= pop_slot_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg <= SCAN_END))
        else $error("scan counter past the table depth");

    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_valid_reg || m_ready)) |=> (m_valid_reg && s_ready))
        else $error("finished word not handed to the result register");

    a_reply_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |-> (res_reg.reply_valid == (res_reg.status == STS_SYNACK)))
        else $error("reply flag out of step with status");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the handshake connection table
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hct_pkg::*;

    // table sizes of the instance under test, mirrored by the predictor below
    localparam int PEND_SLOTS  = 8;
    localparam int EST_SLOTS   = 8;
    // peers that the traffic draws from, so that syn, ack and accept meet again
    localparam int POOL_N      = 12;
    // receiver hold-off for the backlog test, long enough to fill the block
    localparam int HOLD_CYCLES = 300;
    // cycles with no word accepted on either side before the run gives up
    localparam int STALL_LIMIT = 4000;
    // wait after the last owed result, before the verdict
    localparam int SETTLE      = 3 * (EST_SLOTS + 5);

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     [31:0] cfg_wdata = '0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    hct_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    hct_out_t m_data;

    always #2 aclk = ~aclk;

    handshake_connection_table #(
        .PENDING_SLOTS     (PEND_SLOTS),
        .ESTABLISHED_SLOTS (EST_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------
    // predictor state: both peer tables and the syn-ack sequence register
    // ------------------------------------------------------------------
    logic              pend_used [PEND_SLOTS];
    logic [PEER_W-1:0] pend_peer [PEND_SLOTS];
    logic              est_used  [EST_SLOTS];
    logic [PEER_W-1:0] est_peer  [EST_SLOTS];
    logic [31:0]       synack_seq;

    logic [PEER_W-1:0] peer_pool [POOL_N];

    // results owed by the block, oldest first
    hct_out_t outcomes_due [$];
    hct_out_t outcome_head;

    int failures        = 0;
    int words_sent      = 0;
    int words_ignored   = 0;
    int status_seen [16];
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    logic hold_go       = 1'b0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    // works out the result of one accepted word and updates the tables
    function automatic hct_out_t predict_outcome(input hct_in_t w);
        hct_out_t          r;
        logic [PEER_W-1:0] peer;
        int                free_idx;
        int                hit_idx;
        int                i;
        r        = '0;
        peer     = {w.peer_addr, w.peer_port};
        free_idx = -1;
        hit_idx  = -1;
        if (w.command == CMD_ACCEPT) begin
            // pop the lowest established slot
            r.status = STS_EMPTY;
            for (i = 0; i < EST_SLOTS; i++)
                if (est_used[i] && hit_idx < 0) hit_idx = i;
            if (hit_idx >= 0) begin
                est_used[hit_idx] = 1'b0;
                r.status   = STS_POPPED;
                r.slot     = SLOT_W'(hit_idx);
                r.out_addr = est_peer[hit_idx][47:16];
                r.out_port = est_peer[hit_idx][15:0];
            end
        end else if (w.syn_flag && !w.ack_flag) begin
            // a match anywhere wins over a free slot found earlier
            for (i = 0; i < PEND_SLOTS; i++) begin
                if (pend_used[i]) begin
                    if (pend_peer[i] == peer) hit_idx = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit_idx >= 0) begin
                r.status = STS_DUP_PEND;
            end else if (free_idx < 0) begin
                r.status = STS_PEND_FULL;
            end else begin
                pend_used[free_idx] = 1'b1;
                pend_peer[free_idx] = peer;
                r.status      = STS_SYNACK;
                r.reply_valid = 1'b1;
                r.reply_seq   = synack_seq;
                r.reply_ack   = w.seq_num + 32'd1;
                r.slot        = SLOT_W'(free_idx);
            end
        end else if (!w.syn_flag && w.ack_flag) begin
            // established table first, then the pending lookup
            for (i = 0; i < EST_SLOTS; i++) begin
                if (est_used[i]) begin
                    if (est_peer[i] == peer) hit_idx = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit_idx >= 0) begin
                r.status = STS_DUP_ESTAB;
            end else if (free_idx < 0) begin
                r.status = STS_ESTAB_FULL;
            end else begin
                for (i = 0; i < PEND_SLOTS; i++)
                    if (pend_used[i] && pend_peer[i] == peer && hit_idx < 0) hit_idx = i;
                if (hit_idx < 0) begin
                    r.status = STS_NOT_PEND;
                end else begin
                    pend_used[hit_idx]  = 1'b0;
                    est_used[free_idx]  = 1'b1;
                    est_peer[free_idx]  = peer;
                    r.status  = STS_ESTAB;
                    r.slot    = SLOT_W'(free_idx);
                    r.out_seq = w.seq_num;
                    r.out_ack = w.ack_num;
                end
            end
        end else begin
            r.status = STS_IGNORED;
        end
        return r;
    endfunction

    function automatic string outcome_text(input hct_out_t r);
        return {$sformatf("sts=%0d rv=%0b rseq=%h rack=%h slot=%0d",
                          r.status, r.reply_valid, r.reply_seq, r.reply_ack, r.slot),
                $sformatf(" addr=%h port=%h seq=%h ack=%h",
                          r.out_addr, r.out_port, r.out_seq, r.out_ack)};
    endfunction

    function automatic hct_in_t segment_word(input logic syn, input logic ack,
                                             input logic [PEER_W-1:0] peer,
                                             input logic [31:0] seq, input logic [31:0] ackn);
        hct_in_t w;
        w.command   = CMD_SEGMENT;
        w.syn_flag  = syn;
        w.ack_flag  = ack;
        w.peer_addr = peer[47:16];
        w.peer_port = peer[15:0];
        w.seq_num   = seq;
        w.ack_num   = ackn;
        return w;
    endfunction

    // accept request: every other field is don't-care, so keep it random
    function automatic hct_in_t accept_word();
        hct_in_t w;
        w          = segment_word(1'($urandom), 1'($urandom),
                                  {$urandom(), 16'($urandom())}, $urandom(), $urandom());
        w.command  = CMD_ACCEPT;
        return w;
    endfunction

    // mostly well-formed handshakes on pool peers, with some noise mixed in
    function automatic hct_in_t random_word(input int accept_pct);
        logic [PEER_W-1:0] peer;
        logic              waiting;
        logic              flag;
        int                pick;
        int                i;
        pick    = $urandom_range(99);
        peer    = peer_pool[$urandom_range(POOL_N - 1)];
        waiting = 1'b0;
        for (i = 0; i < PEND_SLOTS; i++)
            if (pend_used[i] && pend_peer[i] == peer) waiting = 1'b1;
        if (pick < accept_pct)
            return accept_word();
        if (pick < accept_pct + 5) begin
            // both flags set or both clear
            flag = 1'($urandom);
            return segment_word(flag, flag, peer, $urandom(), $urandom());
        end
        if (pick < accept_pct + 10) begin
            // stranger peer, either flag
            flag = 1'($urandom);
            return segment_word(flag, ~flag, {$urandom(), 16'($urandom())},
                                $urandom(), $urandom());
        end
        if (waiting)
            flag = ($urandom_range(99) < 75);
        else
            flag = ($urandom_range(99) < 20);
        return segment_word(~flag, flag, peer, $urandom(), $urandom());
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    task automatic send_word(input hct_in_t w);
        hct_out_t want;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: predict in acceptance order
        want = predict_outcome(w);
        outcomes_due.push_back(want);
        words_sent++;
        if (want.status == STS_IGNORED) words_ignored++;
        status_seen[want.status]++;
    endtask

    // lowers valid and waits until every owed result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic set_initial_seq(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        synack_seq  = value;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, wrap of the syn-ack acknowledgement, duplicates, near-miss peers,
    // empty accept, unknown ack, odd flag pairs and a full pending table
    task automatic test_edge_cases();
        int k;
        set_initial_seq(32'hFFFF_FFFF);
        send_word(accept_word());
        send_word(segment_word(1'b0, 1'b1, peer_pool[0], 32'h0, 32'hFFFF_FFFF));
        send_word(segment_word(1'b1, 1'b1, peer_pool[0], $urandom(), $urandom()));
        send_word(segment_word(1'b0, 1'b0, peer_pool[1], $urandom(), $urandom()));
        // acknowledgement wraps to zero
        send_word(segment_word(1'b1, 1'b0, peer_pool[0], 32'hFFFF_FFFF, 32'h0));
        send_word(segment_word(1'b1, 1'b0, peer_pool[0], 32'h1234_5678, 32'h0));
        send_word(segment_word(1'b1, 1'b0, peer_pool[1], 32'h0, 32'h0));
        // same address, port one bit off: a different peer
        send_word(segment_word(1'b1, 1'b0, peer_pool[2], 32'h7FFF_FFFF, 32'h0));
        send_word(segment_word(1'b0, 1'b1, peer_pool[0], 32'hFFFF_FFFF, 32'h0000_0000));
        // free slot 0 ahead of the duplicate still gives already pending
        send_word(segment_word(1'b1, 1'b0, peer_pool[2], $urandom(), $urandom()));
        // established table is looked at before the pending one
        send_word(segment_word(1'b0, 1'b1, peer_pool[0], 32'h0, 32'hFFFF_FFFF));
        send_word(accept_word());
        send_word(accept_word());
        for (k = 3; k <= 8; k++)
            send_word(segment_word(1'b1, 1'b0, peer_pool[k], $urandom(), $urandom()));
        send_word(segment_word(1'b1, 1'b0, peer_pool[9], $urandom(), $urandom()));
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits
    task automatic test_result_backlog();
        int k;
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        for (k = 0; k < 10; k++)
            send_word(random_word(20));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_words, input int accept_pct,
                                       input int s_idle, input int r_stall,
                                       input logic [31:0] seq_value);
        int target;
        wait_drained();
        set_initial_seq(seq_value);
        sender_idle_pct = s_idle;
        recv_stall_pct <= r_stall;
        target = words_sent - words_ignored + n_words;
        while (words_sent - words_ignored < target)
            send_word(random_word(accept_pct));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_go) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: each word against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing owed: %s", $time, outcome_text(m_data));
            end else begin
                outcome_head = outcomes_due.pop_front();
                if (m_data !== outcome_head) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result mismatch", $time);
                        $display("  expected %s", outcome_text(outcome_head));
                        $display("  actual   %s", outcome_text(m_data));
                    end
                end
            end
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word accepted for %0d cycles, %0d results still owed",
                     STALL_LIMIT, outcomes_due.size());
            $display("handshake_connection_table verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < 16; k++) status_seen[k] = 0;
        for (k = 0; k < PEND_SLOTS; k++) pend_used[k] = 1'b0;
        for (k = 0; k < EST_SLOTS; k++) est_used[k] = 1'b0;
        synack_seq = '0;

        // pool: all-ones peer, all-zeros peer, a port twin of the first,
        // random peers and two twins differing in a single bit
        peer_pool[0] = {32'hFFFF_FFFF, 16'hFFFF};
        peer_pool[1] = '0;
        peer_pool[2] = {32'hFFFF_FFFF, 16'hFFFE};
        for (k = 3; k < POOL_N; k++) peer_pool[k] = {$urandom(), 16'($urandom())};
        peer_pool[9]  = peer_pool[3] ^ 48'h0000_0000_8000;
        peer_pool[10] = peer_pool[4] ^ 48'h0001_0000_0000;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_edge_cases();
        test_random_traffic(340, 20, 0, 0, 32'h0000_0000);
        test_result_backlog();
        test_random_traffic(340, 10, 54, 0, $urandom());
        test_random_traffic(340, 30, 0, 54, 32'h8000_0000);
        test_random_traffic(340, 20, 10, 10, $urandom());

        // let anything stray come out before the verdict
        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (outcomes_due.size() != 0) begin
            failures++;
            $display("%0d results never arrived", outcomes_due.size());
        end
        $display("run: %0d words (%0d odd flag pairs), four idle/stall mixes, long hold-off",
                 words_sent, words_ignored);
        $write("statuses: synack %0d dup-pend %0d pend-full %0d estab %0d dup-estab %0d",
               status_seen[STS_SYNACK], status_seen[STS_DUP_PEND], status_seen[STS_PEND_FULL],
               status_seen[STS_ESTAB], status_seen[STS_DUP_ESTAB]);
        $display(" estab-full %0d not-pend %0d popped %0d empty %0d",
                 status_seen[STS_ESTAB_FULL], status_seen[STS_NOT_PEND],
                 status_seen[STS_POPPED], status_seen[STS_EMPTY]);
        if (failures == 0) begin
            $display("handshake_connection_table verification clean");
        end else begin
            $display("%0d failures", failures);
            $display("handshake_connection_table verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hct_pkg.sv
hw/rtl/hct_table.sv
hw/rtl/handshake_connection_table.sv
dv/testbench.sv
